@@ src/vgdcm_pkg.sv @@
`timescale 1ns / 1ps
// Package for the voxel grid dirty chunk marker: sizes, register indexes,
// controller state type and the command and status groups.
// No dependencies.

package vgdcm_pkg;

  // Grid geometry
  localparam int GRID_DIM    = 32;
  localparam int CHUNK_SIZE  = 8;
  localparam int TILE_BITS   = 8;
  localparam int COORD_W     = $clog2(GRID_DIM);
  localparam int SIZE_W      = COORD_W + 1;
  localparam int CHUNK_SHIFT = $clog2(CHUNK_SIZE);
  localparam int CHUNK_MASK  = CHUNK_SIZE - 1;
  localparam int CHUNK_W     = COORD_W - CHUNK_SHIFT;
  localparam int CIDX_W      = 3 * CHUNK_W;
  localparam int NUM_CHUNKS  = 1 << CIDX_W;
  localparam int ADDR_W      = 3 * COORD_W;
  localparam int GRID_TILES  = 1 << ADDR_W;

  // Tile values on the ports and the widest stored tile
  localparam int VALUE_W     = 8;
  localparam int TILE_EXT_W  = 16;
  localparam int TILE_VOID   = 0;

  // Request codes
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SIZE_W;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH  = 2'd2;

  // Neighbour walk: bits [2:1] pick the axis, bit 0 picks the plus side
  localparam int NB_CNT_W = 3;
  localparam logic [NB_CNT_W-1:0] NB_LAST = 3'd5;
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CTR_RD,
    ST_CTR_EVAL,
    ST_OLD_MARK,
    ST_NEW_MARK,
    ST_NB_RD,
    ST_NB_EVAL,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    MARK_OLD,
    MARK_NEW,
    MARK_NB
  } mark_sel_t;

  typedef struct packed {
    logic      clr_step;
    logic      take_item;
    logic      rd_center;
    logic      eval_center;
    logic      mark_go;
    mark_sel_t mark_sel;
    logic      nb_clear;
    logic      nb_step;
    logic      rd_nb;
    logic      flush;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_valid;
    logic ctr_changed;
    logic old_nonempty;
    logic new_nonempty;
    logic can_push;
    logic nb_ok;
    logic nb_last;
    logic nb_hit;
  } status_t;

endpackage

@@ src/vgdcm_in_if.sv @@
`timescale 1ns / 1ps
// Request channel of the voxel grid dirty chunk marker.
// Depends on vgdcm_pkg.

interface vgdcm_in_if;
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic [vgdcm_pkg::COORD_W-1:0]   pos_x;
  logic [vgdcm_pkg::COORD_W-1:0]   pos_y;
  logic [vgdcm_pkg::COORD_W-1:0]   pos_z;
  logic [vgdcm_pkg::VALUE_W-1:0]   tile_value;

  modport source (output valid, req_type, pos_x, pos_y, pos_z, tile_value, input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, pos_z, tile_value, output ready);
endinterface

@@ src/vgdcm_out_if.sv @@
`timescale 1ns / 1ps
// Result channel of the voxel grid dirty chunk marker.
// Depends on vgdcm_pkg.

interface vgdcm_out_if;
  logic                            valid;
  logic                            ready;
  logic [vgdcm_pkg::VALUE_W-1:0]   read_value;
  logic                            mark_valid;
  logic [vgdcm_pkg::CHUNK_W-1:0]   chunk_x;
  logic [vgdcm_pkg::CHUNK_W-1:0]   chunk_y;
  logic [vgdcm_pkg::CHUNK_W-1:0]   chunk_z;
  logic [vgdcm_pkg::VALUE_W-1:0]   dirty_type;
  logic                            chunk_new;
  logic                            last;

  modport source (output valid, read_value, mark_valid, chunk_x, chunk_y, chunk_z,
                  dirty_type, chunk_new, last, input ready);
  modport sink   (input valid, read_value, mark_valid, chunk_x, chunk_y, chunk_z,
                  dirty_type, chunk_new, last, output ready);
endinterface

@@ src/vgdcm_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.

module vgdcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, or read into the output register
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/vgdcm_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the voxel grid dirty chunk marker: sequences the clearing
// pass, the tile lookup, the mark candidates and the result flush.
// Depends on vgdcm_pkg.

module vgdcm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  vgdcm_pkg::status_t  status,
  output vgdcm_pkg::cmd_t     cmd
);

  vgdcm_pkg::state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vgdcm_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vgdcm_pkg::ST_CLEAR: begin
        if (status.clr_done) state_nxt = vgdcm_pkg::ST_IDLE;
      end
      vgdcm_pkg::ST_IDLE: begin
        if (status.in_valid) state_nxt = vgdcm_pkg::ST_CTR_RD;
      end
      vgdcm_pkg::ST_CTR_RD: begin
        state_nxt = vgdcm_pkg::ST_CTR_EVAL;
      end
      vgdcm_pkg::ST_CTR_EVAL: begin
        state_nxt = status.ctr_changed ? vgdcm_pkg::ST_OLD_MARK : vgdcm_pkg::ST_FLUSH;
      end
      vgdcm_pkg::ST_OLD_MARK: begin
        if (!status.old_nonempty || status.can_push) begin
          state_nxt = status.new_nonempty ? vgdcm_pkg::ST_NEW_MARK : vgdcm_pkg::ST_NB_RD;
        end
      end
      vgdcm_pkg::ST_NEW_MARK: begin
        if (status.can_push) begin
          state_nxt = status.old_nonempty ? vgdcm_pkg::ST_FLUSH : vgdcm_pkg::ST_NB_RD;
        end
      end
      vgdcm_pkg::ST_NB_RD: begin
        if (status.nb_ok) begin
          state_nxt = vgdcm_pkg::ST_NB_EVAL;
        end else if (status.nb_last) begin
          state_nxt = vgdcm_pkg::ST_FLUSH;
        end
      end
      vgdcm_pkg::ST_NB_EVAL: begin
        if (!status.nb_hit || status.can_push) begin
          state_nxt = status.nb_last ? vgdcm_pkg::ST_FLUSH : vgdcm_pkg::ST_NB_RD;
        end
      end
      vgdcm_pkg::ST_FLUSH: begin
        if (status.can_push) state_nxt = vgdcm_pkg::ST_IDLE;
      end
      default: state_nxt = vgdcm_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd = '0;
    cmd.mark_sel = vgdcm_pkg::MARK_NB;
    unique case (state_r)
      vgdcm_pkg::ST_CLEAR:    cmd.clr_step = 1'b1;
      vgdcm_pkg::ST_IDLE:     cmd.take_item = 1'b1;
      vgdcm_pkg::ST_CTR_RD:   cmd.rd_center = 1'b1;
      vgdcm_pkg::ST_CTR_EVAL: begin
        cmd.eval_center = 1'b1;
        cmd.nb_clear    = 1'b1;
      end
      vgdcm_pkg::ST_OLD_MARK: begin
        cmd.mark_sel = vgdcm_pkg::MARK_OLD;
        cmd.mark_go  = status.old_nonempty && status.can_push;
      end
      vgdcm_pkg::ST_NEW_MARK: begin
        cmd.mark_sel = vgdcm_pkg::MARK_NEW;
        cmd.mark_go  = status.can_push;
      end
      vgdcm_pkg::ST_NB_RD: begin
        cmd.rd_nb   = status.nb_ok;
        cmd.nb_step = !status.nb_ok && !status.nb_last;
      end
      vgdcm_pkg::ST_NB_EVAL: begin
        cmd.mark_go = status.nb_hit && status.can_push;
        cmd.nb_step = (!status.nb_hit || status.can_push) && !status.nb_last;
      end
      vgdcm_pkg::ST_FLUSH:    cmd.flush = status.can_push;
      default:                cmd = '0;
    endcase
  end

endmodule

@@ src/vgdcm_dpath.sv @@
`timescale 1ns / 1ps
// Datapath of the voxel grid dirty chunk marker: size registers, item
// registers, tile RAM, chunk presence bits, pending result and output register.
// Depends on vgdcm_pkg, vgdcm_in_if, vgdcm_out_if and vgdcm_ram.

module vgdcm_dpath #(
  parameter int TILE_BITS = vgdcm_pkg::TILE_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  vgdcm_in_if.sink                           in_ch,
  vgdcm_out_if.source                        out_ch,
  input  logic                               cfg_we,
  input  logic [vgdcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vgdcm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  vgdcm_pkg::cmd_t                    cmd,
  output vgdcm_pkg::status_t                 status
);

  localparam int COORD_W = vgdcm_pkg::COORD_W;
  localparam int SIZE_W  = vgdcm_pkg::SIZE_W;
  localparam int CSH     = vgdcm_pkg::CHUNK_SHIFT;
  localparam int EXT_W   = vgdcm_pkg::TILE_EXT_W;
  localparam int VAL_W   = vgdcm_pkg::VALUE_W;

  typedef struct packed {
    logic [VAL_W-1:0]              read_value;
    logic                          mark_valid;
    logic [vgdcm_pkg::CHUNK_W-1:0] chunk_x;
    logic [vgdcm_pkg::CHUNK_W-1:0] chunk_y;
    logic [vgdcm_pkg::CHUNK_W-1:0] chunk_z;
    logic [VAL_W-1:0]              dirty_type;
    logic                          chunk_new;
    logic                          last;
  } res_t;

  localparam logic [TILE_BITS-1:0] EMPTY = TILE_BITS'(vgdcm_pkg::TILE_VOID);

  // Size registers
  logic [SIZE_W-1:0] width_r, height_r, depth_r, size_sat;

  // Item registers
  logic                 req_r;
  logic [COORD_W-1:0]   x_r, y_r, z_r;
  logic [TILE_BITS-1:0] nt_r, ot_r;
  logic [EXT_W-1:0]     tv_ext;

  // Control registers
  logic [vgdcm_pkg::NB_CNT_W-1:0]   nb_r;
  logic [vgdcm_pkg::ADDR_W-1:0]     clr_r;
  logic [vgdcm_pkg::NUM_CHUNKS-1:0] present_r, present_nxt;
  logic                             pend_v_r, pend_v_nxt, out_v_r, out_v_nxt;
  res_t                             pend_r, pend_nxt, out_r, out_nxt;

  // RAM port
  logic                          ram_we, ram_re;
  logic [vgdcm_pkg::ADDR_W-1:0]  ram_addr;
  logic [TILE_BITS-1:0]          ram_wdata, ram_rdata;

  // Neighbour and mark candidate
  logic [SIZE_W-1:0]              nx, ny, nz, nb_step_v;
  logic [COORD_W-1:0]             cur;
  logic [1:0]                     axis;
  logic                           minus, low_edge, nb_border, nb_ok, nb_hit;
  logic                           center_in, ctr_changed, can_push;
  logic [COORD_W-1:0]             mk_x, mk_y, mk_z;
  logic [TILE_BITS-1:0]           mk_type;
  logic [vgdcm_pkg::CIDX_W-1:0]   mk_idx;
  res_t                           mk_res;

  // Saturate size writes to the grid dimension
  always_comb begin
    size_sat = (cfg_data > SIZE_W'(vgdcm_pkg::GRID_DIM)) ?
               SIZE_W'(vgdcm_pkg::GRID_DIM) : cfg_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(vgdcm_pkg::GRID_DIM);
      height_r <= SIZE_W'(vgdcm_pkg::GRID_DIM);
      depth_r  <= SIZE_W'(vgdcm_pkg::GRID_DIM);
    end else if (cfg_we) begin
      unique case (cfg_index)
        vgdcm_pkg::REG_GRID_WIDTH:  width_r  <= size_sat;
        vgdcm_pkg::REG_GRID_HEIGHT: height_r <= size_sat;
        vgdcm_pkg::REG_GRID_DEPTH:  depth_r  <= size_sat;
        default: ;
      endcase
    end
  end

  // Capture the item on a transfer
  assign tv_ext      = EXT_W'(in_ch.tile_value);
  assign in_ch.ready = cmd.take_item;

  always_ff @(posedge clk) begin
    if (cmd.take_item && in_ch.valid) begin
      req_r <= in_ch.req_type;
      x_r   <= in_ch.pos_x;
      y_r   <= in_ch.pos_y;
      z_r   <= in_ch.pos_z;
      nt_r  <= tv_ext[TILE_BITS-1:0];
    end
    if (cmd.eval_center) begin
      ot_r <= ram_rdata;
    end
  end

  // Neighbour coordinates, bounds and chunk border
  always_comb begin
    axis  = nb_r[2:1];
    minus = ~nb_r[0];
    case (axis)
      vgdcm_pkg::AXIS_X: cur = x_r;
      vgdcm_pkg::AXIS_Y: cur = y_r;
      default:           cur = z_r;
    endcase
    nb_step_v = minus ? (SIZE_W'(cur) - SIZE_W'(1)) : (SIZE_W'(cur) + SIZE_W'(1));
    nx = SIZE_W'(x_r);
    ny = SIZE_W'(y_r);
    nz = SIZE_W'(z_r);
    case (axis)
      vgdcm_pkg::AXIS_X: nx = nb_step_v;
      vgdcm_pkg::AXIS_Y: ny = nb_step_v;
      default:           nz = nb_step_v;
    endcase
    low_edge  = minus && (cur == '0);
    nb_border = minus ? (cur[CSH-1:0] == '0) :
                        (cur[CSH-1:0] == CSH'(vgdcm_pkg::CHUNK_MASK));
    nb_ok     = !low_edge && (nx < width_r) && (ny < height_r) && (nz < depth_r);
  end

  // Centre lookup outcome and neighbour filter
  assign center_in   = (SIZE_W'(x_r) < width_r) && (SIZE_W'(y_r) < height_r) &&
                       (SIZE_W'(z_r) < depth_r);
  assign ctr_changed = (req_r == vgdcm_pkg::REQ_WRITE) && center_in && (ram_rdata != nt_r);
  assign nb_hit      = (ram_rdata != EMPTY) &&
                       ((nt_r != EMPTY) || nb_border || (ram_rdata != ot_r));

  // Tile RAM port: clearing pass, centre write, centre or neighbour read
  always_comb begin
    ram_we    = cmd.clr_step || (cmd.eval_center && ctr_changed);
    ram_re    = cmd.rd_center || cmd.rd_nb;
    ram_wdata = cmd.clr_step ? '0 : nt_r;
    if (cmd.clr_step) begin
      ram_addr = clr_r;
    end else if (cmd.rd_nb) begin
      ram_addr = {nx[COORD_W-1:0], ny[COORD_W-1:0], nz[COORD_W-1:0]};
    end else begin
      ram_addr = {x_r, y_r, z_r};
    end
  end

  vgdcm_ram #(
    .WIDTH (TILE_BITS),
    .DEPTH (vgdcm_pkg::GRID_TILES)
  ) u_tile_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Build the mark candidate
  always_comb begin
    logic [EXT_W-1:0] ty_ext;
    case (cmd.mark_sel)
      vgdcm_pkg::MARK_OLD: begin
        mk_x = x_r; mk_y = y_r; mk_z = z_r; mk_type = ot_r;
      end
      vgdcm_pkg::MARK_NEW: begin
        mk_x = x_r; mk_y = y_r; mk_z = z_r; mk_type = nt_r;
      end
      default: begin
        mk_x = nx[COORD_W-1:0]; mk_y = ny[COORD_W-1:0]; mk_z = nz[COORD_W-1:0];
        mk_type = ram_rdata;
      end
    endcase
    ty_ext            = EXT_W'(mk_type);
    mk_res            = '0;
    mk_res.mark_valid = 1'b1;
    mk_res.chunk_x    = mk_x[COORD_W-1:CSH];
    mk_res.chunk_y    = mk_y[COORD_W-1:CSH];
    mk_res.chunk_z    = mk_z[COORD_W-1:CSH];
    mk_idx            = {mk_res.chunk_x, mk_res.chunk_y, mk_res.chunk_z};
    mk_res.dirty_type = ty_ext[VAL_W-1:0];
    mk_res.chunk_new  = ~present_r[mk_idx];
  end

  // Pending result, output register and presence bits
  assign can_push = !pend_v_r || !out_v_r || out_ch.ready;

  always_comb begin
    logic [EXT_W-1:0] rd_ext;
    rd_ext      = EXT_W'(ram_rdata);
    pend_v_nxt  = pend_v_r;
    pend_nxt    = pend_r;
    out_v_nxt   = out_v_r && !out_ch.ready;
    out_nxt     = out_r;
    present_nxt = present_r;
    if (cmd.eval_center && !ctr_changed) begin
      pend_v_nxt = 1'b1;
      pend_nxt   = '0;
      if ((req_r == vgdcm_pkg::REQ_READ) && center_in) begin
        pend_nxt.read_value = rd_ext[VAL_W-1:0];
      end
    end
    if (cmd.mark_go) begin
      if (pend_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt   = pend_r;
      end
      pend_v_nxt          = 1'b1;
      pend_nxt            = mk_res;
      present_nxt[mk_idx] = 1'b1;
    end
    if (cmd.flush) begin
      out_v_nxt    = 1'b1;
      out_nxt      = pend_r;
      out_nxt.last = 1'b1;
      pend_v_nxt   = 1'b0;
    end
  end

  // Advance control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nb_r      <= '0;
      clr_r     <= '0;
      present_r <= '0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (cmd.nb_clear) begin
        nb_r <= '0;
      end else if (cmd.nb_step) begin
        nb_r <= nb_r + 1'b1;
      end
      if (cmd.clr_step && (clr_r != '1)) begin
        clr_r <= clr_r + 1'b1;
      end
      present_r <= present_nxt;
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  // Hold result payloads
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  // Drive the result channel
  assign out_ch.valid      = out_v_r;
  assign out_ch.read_value = out_r.read_value;
  assign out_ch.mark_valid = out_r.mark_valid;
  assign out_ch.chunk_x    = out_r.chunk_x;
  assign out_ch.chunk_y    = out_r.chunk_y;
  assign out_ch.chunk_z    = out_r.chunk_z;
  assign out_ch.dirty_type = out_r.dirty_type;
  assign out_ch.chunk_new  = out_r.chunk_new;
  assign out_ch.last       = out_r.last;

  // Status to the controller
  always_comb begin
    status              = '0;
    status.clr_done     = (clr_r == '1);
    status.in_valid     = in_ch.valid;
    status.ctr_changed  = ctr_changed;
    status.old_nonempty = (ot_r != EMPTY);
    status.new_nonempty = (nt_r != EMPTY);
    status.can_push     = can_push;
    status.nb_ok        = nb_ok;
    status.nb_last      = (nb_r == vgdcm_pkg::NB_LAST);
    status.nb_hit       = nb_hit;
  end

endmodule

@@ src/voxel_grid_dirty_chunk_marker.sv @@
`timescale 1ns / 1ps
// Voxel grid dirty chunk marker: 32x32x32 tile grid in one single-port RAM
// with a 64-entry chunk presence map. After reset the block runs a clearing
// pass over all 32768 tiles, one tile per cycle, before it takes the first request;
// configuration writes are taken throughout. Requests are handled one at a
// time and every tile or neighbour lookup is one access to the tile RAM followed
// by an evaluation of the registered read data. A write that fills or empties
// a tile also looks up its six neighbours, skipping those outside the grid.
// Results leave through an output register, so a new request is accepted
// while the previous final result waits; a stalled output holds the sequencer.
// Depends on vgdcm_pkg, vgdcm_in_if, vgdcm_out_if, vgdcm_ctrl and vgdcm_dpath.

module voxel_grid_dirty_chunk_marker #(
  parameter int TILE_BITS = vgdcm_pkg::TILE_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  vgdcm_in_if.sink                           in_ch,
  vgdcm_out_if.source                        out_ch,
  input  logic                               cfg_we,
  input  logic [vgdcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vgdcm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  vgdcm_pkg::cmd_t    cmd;
  vgdcm_pkg::status_t status;

  vgdcm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  vgdcm_dpath #(
    .TILE_BITS (TILE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
